>>> rtl/sorted_table_binary_insert_assert.svh
// Assertion helpers for the RTL of the sorted key table, used by sti_ctrl.
// Every check is clocked on clk_i and held off while rst_ni is low.
`ifndef SORTED_TABLE_BINARY_INSERT_ASSERT_SVH
`define SORTED_TABLE_BINARY_INSERT_ASSERT_SVH

// Property must hold at every clock edge out of reset.
`define STB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define STB_ASSERT_NEVER(lbl, cond, msg) \
  `STB_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/sti_pkg.sv
package sti_pkg;

  // Default geometry of the table
  localparam int unsigned DEPTH_DEF = 256;
  localparam int unsigned KEY_W_DEF = 32;

  // Fixed field widths of the transaction ports
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned CNT_OUT_W = 9;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_READ_OK   = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_e;

  // Result info handed from the engine to the output register
  typedef struct packed {
    status_e              status;
    logic [POS_W-1:0]     position;
    logic [CNT_OUT_W-1:0] entry_count;
  } res_info_t;

endpackage

>>> rtl/sti_ram.sv
module sti_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sti_ctrl.sv
module sti_ctrl #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            operation_i,
  input  logic [KEY_WIDTH-1:0]            key_i,
  input  logic [sti_pkg::IDX_W-1:0]       index_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output sti_pkg::res_info_t              res_info_o,
  output logic [KEY_WIDTH-1:0]            res_key_o,
  output logic                            ram_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]  ram_waddr_o,
  output logic [KEY_WIDTH-1:0]            ram_wdata_o,
  output logic                            ram_re_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]  ram_raddr_o,
  input  logic [KEY_WIDTH-1:0]            ram_rdata_i
);

  import sti_pkg::*;

`include "sorted_table_binary_insert_assert.svh"

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // Engine states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SRCH_RD  = 3'd1;
  localparam logic [2:0] S_SRCH_CMP = 3'd2;
  localparam logic [2:0] S_SHIFT    = 3'd3;
  localparam logic [2:0] S_PUT      = 3'd4;
  localparam logic [2:0] S_RD_WAIT  = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 allow_dup_q;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [CNT_W-1:0]     left_q, left_d;
  logic [CNT_W-1:0]     right_q, right_d;
  logic [CNT_W-1:0]     mid_q, mid_d;
  logic [CNT_W-1:0]     pos_q, pos_d;
  logic [CNT_W-1:0]     sh_i_q, sh_i_d;
  logic                 sh_wv_q, sh_wv_d;
  logic [ADDR_W-1:0]    sh_wa_q, sh_wa_d;
  status_e              status_q, status_d;
  logic [KEY_WIDTH-1:0] rk_q, rk_d;

  logic [CNT_W:0]       mid_sum;
  logic [CNT_W-1:0]     mid_calc;
  logic [CNT_W-1:0]     mid_m1;
  logic [CNT_W-1:0]     sh_i_m1;
  logic [CNT_W+IDX_W-1:0]  idx_ext;
  logic [CNT_W+IDX_W-1:0]  cnt_ext;
  logic [ADDR_W+IDX_W-1:0] idx_addr;
  logic [CNT_W+POS_W:0]    pos_wide;
  logic [CNT_W+CNT_OUT_W:0] cnt_wide;
  logic                 key_lt, key_eq;
  logic                 left_adj, right_adj;

  // Midpoint of the current search window and its zero-based entry
  assign mid_sum  = {1'b0, left_q} + {1'b0, right_q};
  assign mid_calc = mid_sum[CNT_W:1];
  assign mid_m1   = mid_q - CNT_ONE;
  assign sh_i_m1  = sh_i_q - CNT_ONE;

  // Signed key compare against the entry just read
  assign key_lt = $signed(key_q) < $signed(ram_rdata_i);
  assign key_eq = key_q == ram_rdata_i;

  // Window closes once the bounds become neighbors
  assign left_adj  = ({1'b0, left_q} + {{CNT_W{1'b0}}, 1'b1}) == {1'b0, mid_q};
  assign right_adj = ({1'b0, mid_q} + {{CNT_W{1'b0}}, 1'b1}) == {1'b0, right_q};

  // Read index against the count at a common width
  assign idx_ext  = {{CNT_W{1'b0}}, index_i};
  assign cnt_ext  = {{IDX_W{1'b0}}, count_q};
  assign idx_addr = {{ADDR_W{1'b0}}, index_i};

  assign in_stall_o = state_q != S_IDLE;

  // Next-state and memory request logic
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    key_d       = key_q;
    left_d      = left_q;
    right_d     = right_q;
    mid_d       = mid_q;
    pos_d       = pos_q;
    sh_i_d      = sh_i_q;
    sh_wv_d     = sh_wv_q;
    sh_wa_d     = sh_wa_q;
    status_d    = status_q;
    rk_d        = rk_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = sh_wa_q;
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = mid_m1[ADDR_W-1:0];
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d  = key_i;
          pos_d  = '0;
          rk_d   = '0;
          sh_wv_d = 1'b0;
          if (operation_i == OP_READ) begin
            if (idx_ext < cnt_ext) begin
              ram_re_o    = 1'b1;
              ram_raddr_o = idx_addr[ADDR_W-1:0];
              status_d    = ST_READ_OK;
              state_d     = S_RD_WAIT;
            end else begin
              status_d = ST_BAD_INDEX;
              state_d  = S_DONE;
            end
          end else if (count_q >= DEPTH_CNT) begin
            status_d = ST_FULL;
            state_d  = S_DONE;
          end else if (count_q == '0) begin
            sh_i_d  = count_q;
            state_d = S_SHIFT;
          end else begin
            left_d  = '0;
            right_d = count_q + CNT_ONE;
            state_d = S_SRCH_RD;
          end
        end
      end

      S_SRCH_RD: begin
        // Fetch entry mid-1 of the window
        mid_d       = mid_calc;
        ram_re_o    = 1'b1;
        ram_raddr_o = ADDR_W'(mid_calc - CNT_ONE);
        state_d     = S_SRCH_CMP;
      end

      S_SRCH_CMP: begin
        sh_i_d = count_q;
        if (key_eq) begin
          if (!allow_dup_q) begin
            status_d = ST_DUPLICATE;
            state_d  = S_DONE;
          end else begin
            pos_d   = mid_m1;
            state_d = S_SHIFT;
          end
        end else if (key_lt) begin
          right_d = mid_q;
          if (left_adj) begin
            pos_d   = mid_m1;
            state_d = S_SHIFT;
          end else begin
            state_d = S_SRCH_RD;
          end
        end else begin
          left_d = mid_q;
          if (right_adj) begin
            pos_d   = mid_q;
            state_d = S_SHIFT;
          end else begin
            state_d = S_SRCH_RD;
          end
        end
      end

      S_SHIFT: begin
        // Move entry i-1 up to i; each write lands in the cycle after its read, overlapped with the next read
        ram_we_o = sh_wv_q;
        if (sh_i_q > pos_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = sh_i_m1[ADDR_W-1:0];
          sh_wv_d     = 1'b1;
          sh_wa_d     = sh_i_q[ADDR_W-1:0];
          sh_i_d      = sh_i_m1;
        end else begin
          sh_wv_d = 1'b0;
          if (!sh_wv_q) begin
            state_d = S_PUT;
          end
        end
      end

      S_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q[ADDR_W-1:0];
        ram_wdata_o = key_q;
        count_d     = count_q + CNT_ONE;
        status_d    = ST_INSERTED;
        state_d     = S_DONE;
      end

      S_RD_WAIT: begin
        rk_d    = ram_rdata_i;
        state_d = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      allow_dup_q <= 1'b0;
      sh_wv_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sh_wv_q <= sh_wv_d;
      if (cfg_we_i) begin
        allow_dup_q <= cfg_wdata_i;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    left_q   <= left_d;
    right_q  <= right_d;
    mid_q    <= mid_d;
    pos_q    <= pos_d;
    sh_i_q   <= sh_i_d;
    sh_wa_q  <= sh_wa_d;
    status_q <= status_d;
    rk_q     <= rk_d;
  end

  // Result fields, fitted to the port widths
  assign pos_wide = {{(POS_W + 1){1'b0}}, pos_q};
  assign cnt_wide = {{(CNT_OUT_W + 1){1'b0}}, count_q};

  assign res_info_o.status      = status_q;
  assign res_info_o.position    = pos_wide[POS_W-1:0];
  assign res_info_o.entry_count = cnt_wide[CNT_OUT_W-1:0];
  assign res_key_o              = rk_q;

  `STB_ASSERT(a_count_le_depth, count_q <= DEPTH_CNT, "count beyond table depth")
  `STB_ASSERT_NEVER(a_no_write_in_lookup,
    ram_we_o && (state_q == S_SRCH_RD || state_q == S_SRCH_CMP || state_q == S_RD_WAIT),
    "table written during lookup")
  `STB_ASSERT(a_window_order,
    state_q == S_SRCH_CMP |-> (left_q < mid_q && mid_q < right_q),
    "search midpoint outside window")
  `STB_ASSERT(a_put_bumps_count,
    state_q == S_PUT |=> count_q == $past(count_q) + CNT_ONE,
    "insert did not bump count")

endmodule

>>> rtl/sorted_table_binary_insert.sv
// Sorted key table with binary-search insert.
// Input channel (in_valid_i / in_stall_o): operation_i selects insert of
// key_i or read of the entry at index_i. Output channel (out_valid_o /
// out_stall_i) returns one result per transaction: status, position,
// read_key and entry_count. allow_duplicates is written through
// cfg_we_i / cfg_wdata_i, only while the block is idle: the user must keep
// to this, the block does not enforce it. One transaction is in work at a
// time; in_stall_o is high until its result has moved into the output
// register. A read makes one registered table read. An insert runs search
// steps of one registered table read and one compare each, then shifts the
// higher entries up one per cycle through the single write port, stores
// the key and hands the result over. A full table or a rejected duplicate
// ends right after the search or the count check.
// Reset empties the table (count zero, no clearing pass) and clears
// allow_duplicates. While the receiver stalls, the result holds in the
// output register and the block still takes the next transaction and
// works on it until it has a result of its own to hand over.
module sorted_table_binary_insert #(
  parameter int unsigned TABLE_DEPTH = sti_pkg::DEPTH_DEF,
  parameter int unsigned KEY_WIDTH   = sti_pkg::KEY_W_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            operation_i,
  input  logic [KEY_WIDTH-1:0]            key_i,
  input  logic [sti_pkg::IDX_W-1:0]       index_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      status_o,
  output logic [sti_pkg::POS_W-1:0]       position_o,
  output logic [KEY_WIDTH-1:0]            read_key_o,
  output logic [sti_pkg::CNT_OUT_W-1:0]   entry_count_o
);

  import sti_pkg::*;

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

  logic                 res_valid;
  logic                 res_ready;
  res_info_t            res_info;
  logic [KEY_WIDTH-1:0] res_key;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;

  logic                 out_valid_q;
  res_info_t            out_info_q;
  logic [KEY_WIDTH-1:0] out_key_q;

  sti_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .key_i       (key_i),
    .index_i     (index_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_info_o  (res_info),
    .res_key_o   (res_key),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  sti_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (KEY_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register loads when empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_info_q <= res_info;
      out_key_q  <= res_key;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_info_q.status;
  assign position_o    = out_info_q.position;
  assign read_key_o    = out_key_q;
  assign entry_count_o = out_info_q.entry_count;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sti_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEF;
  localparam int unsigned KEY_W       = KEY_W_DEF;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned DRAIN_WAIT  = 300;
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;

  // One answer of the table, as it appears on the result port
  typedef struct packed {
    status_e              status;
    logic [POS_W-1:0]     position;
    logic [KEY_W-1:0]     read_key;
    logic [CNT_OUT_W-1:0] entry_count;
  } table_answer_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic                 cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 operation_i;
  logic [KEY_W-1:0]     key_i;
  logic [IDX_W-1:0]     index_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [2:0]           status_o;
  logic [POS_W-1:0]     position_o;
  logic [KEY_W-1:0]     read_key_o;
  logic [CNT_OUT_W-1:0] entry_count_o;

  // Shadow copy of the table and its setting
  logic signed [KEY_W-1:0] shadow_keys [DEPTH];
  int unsigned             shadow_count;
  bit                      shadow_dups;

  table_answer_t   table_answers [$];
  int unsigned     mismatches;
  bit              hold_off_req;
  longint unsigned cycle_count;

  sorted_table_binary_insert #(
    .TABLE_DEPTH(DEPTH),
    .KEY_WIDTH  (KEY_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .key_i        (key_i),
    .index_i      (index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .position_o   (position_o),
    .read_key_o   (read_key_o),
    .entry_count_o(entry_count_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t timeout after %0d cycles", $time, cycle_count);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Binary-search insert or indexed read against the shadow table
  function automatic table_answer_t apply_table_op(input logic op,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [IDX_W-1:0] idx);
    table_answer_t ans;
    int unsigned   lo, hi, mid, pos, j;
    bit            done, rejected;
    ans.status   = ST_INSERTED;
    ans.position = '0;
    ans.read_key = '0;
    if (op == OP_READ) begin
      if (idx < shadow_count) begin
        ans.status   = ST_READ_OK;
        ans.read_key = shadow_keys[idx];
      end else begin
        ans.status = ST_BAD_INDEX;
      end
    end else if (shadow_count >= DEPTH) begin
      ans.status = ST_FULL;
    end else begin
      pos      = 0;
      rejected = 1'b0;
      if (shadow_count > 0) begin
        lo   = 0;
        hi   = shadow_count + 1;
        done = 1'b0;
        while (!done) begin
          mid = (lo + hi) / 2;
          if ($signed(key) == shadow_keys[mid-1]) begin
            rejected = !shadow_dups;
            pos      = mid - 1;
            done     = 1'b1;
          end else if ($signed(key) < shadow_keys[mid-1]) begin
            hi = mid;
            if (lo + 1 == hi) begin
              pos  = mid - 1;
              done = 1'b1;
            end
          end else begin
            lo = mid;
            if (lo + 1 == hi) begin
              pos  = mid;
              done = 1'b1;
            end
          end
        end
      end
      if (rejected) begin
        ans.status = ST_DUPLICATE;
      end else begin
        // shift the higher entries up and drop the key in
        for (j = shadow_count; j > pos; j--) shadow_keys[j] = shadow_keys[j-1];
        shadow_keys[pos] = key;
        shadow_count++;
        ans.position = pos[POS_W-1:0];
      end
    end
    ans.entry_count = shadow_count[CNT_OUT_W-1:0];
    return ans;
  endfunction

  // Sender idle gap: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Key source: stored keys, extremes, a narrow pool or the full range
  function automatic logic [KEY_W-1:0] pick_key(input int unsigned pool_span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25 && shadow_count > 0) return shadow_keys[$urandom_range(0, shadow_count - 1)];
    if (r < 33) begin
      case ($urandom_range(0, 3))
        0:       return {1'b1, {(KEY_W-1){1'b0}}};
        1:       return {1'b0, {(KEY_W-1){1'b1}}};
        2:       return '0;
        default: return '1;
      endcase
    end
    if (pool_span == 0) return $urandom;
    return KEY_W'($signed($urandom_range(0, pool_span - 1)) - $signed(pool_span / 2));
  endfunction

  // Read index: mostly within the table or just past its end
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 99) < 30 || shadow_count == 0) return IDX_W'($urandom_range(0, 255));
    if (shadow_count >= DEPTH) return IDX_W'($urandom_range(0, DEPTH - 1));
    return IDX_W'($urandom_range(0, shadow_count));
  endfunction

  // Offer one transaction, hold it until taken, then log its answer
  task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                           input logic [IDX_W-1:0] idx);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i  = 1'b1;
    operation_i = op;
    key_i       = key;
    index_i     = idx;
    do @(posedge clk_i); while (in_stall_o);
    table_answers.push_back(apply_table_op(op, key, idx));
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i  = 1'b0;
      operation_i = 1'($urandom);
      key_i       = KEY_W'($urandom);
      index_i     = IDX_W'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_random(input int unsigned pool_span, input int unsigned read_pct);
    if ($urandom_range(0, 99) < read_pct) send_item(OP_READ, KEY_W'($urandom), pick_index());
    else send_item(OP_INSERT, pick_key(pool_span), IDX_W'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (table_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Setting is only changed with the block idle
  task automatic write_dup_mode(input bit allow);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = allow;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    shadow_dups = allow;
  endtask

  task automatic test_empty_table();
    send_item(OP_READ, '0, 8'd0);
    send_item(OP_READ, '1, 8'd255);
    send_item(OP_INSERT, 32'sd5, 8'd0);
  endtask

  task automatic test_key_extremes();
    send_item(OP_INSERT, {1'b0, {(KEY_W-1){1'b1}}}, 8'd0);
    send_item(OP_INSERT, {1'b1, {(KEY_W-1){1'b0}}}, 8'hff);
    send_item(OP_INSERT, '0, 8'd0);
    send_item(OP_INSERT, '1, 8'd0);
    send_item(OP_INSERT, 32'sd1, 8'd0);
    send_item(OP_INSERT, 32'sd5, 8'd0);
    send_item(OP_READ, '0, 8'd0);
    send_item(OP_READ, '0, 8'd5);
    send_item(OP_READ, '0, 8'd6);
    send_item(OP_READ, '0, 8'd255);
  endtask

  task automatic test_duplicates();
    write_dup_mode(1'b1);
    send_item(OP_INSERT, 32'sd5, 8'd0);
    send_item(OP_INSERT, {1'b1, {(KEY_W-1){1'b0}}}, 8'd0);
    send_item(OP_INSERT, '1, 8'd0);
    send_item(OP_READ, '0, 8'd0);
    send_item(OP_READ, '0, 8'd7);
    write_dup_mode(1'b0);
    send_item(OP_INSERT, '0, 8'd0);
    send_item(OP_INSERT, {1'b0, {(KEY_W-1){1'b1}}}, 8'd0);
  endtask

  // Narrow key pool with duplicates rejected: the table grows slowly
  task automatic test_random_narrow_pool();
    repeat (450) send_random(128, 50);
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    repeat (12) send_random(0, 50);
  endtask

  task automatic test_random_wide_keys();
    write_dup_mode(1'b1);
    repeat (250) send_random(64, 50);
    write_dup_mode(1'b0);
    repeat (250) send_random(0, 50);
  endtask

  task automatic test_full_table();
    int unsigned n;
    write_dup_mode(1'b1);
    while (shadow_count < DEPTH) send_item(OP_INSERT, pick_key(0), IDX_W'($urandom));
    // full table answers before any search, even for a stored key
    send_item(OP_INSERT, shadow_keys[$urandom_range(0, DEPTH - 1)], 8'd0);
    send_item(OP_READ, '0, 8'd255);
    send_item(OP_READ, '0, 8'd0);
    write_dup_mode(1'b0);
    send_item(OP_INSERT, shadow_keys[$urandom_range(0, DEPTH - 1)], 8'd0);
    for (n = 0; n < 300; n++) begin
      if (n == 150) write_dup_mode(1'b1);
      send_random(0, 60);
    end
  endtask

  // Receiver stall pattern
  initial begin
    int unsigned run, r;
    out_stall_i = 1'b0;
    run         = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
        out_stall_i  = 1'b0;
        run          = 0;
      end else if (run != 0) begin
        run--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          out_stall_i = 1'b0;
          run         = $urandom_range(0, 40);
        end else if (r < 85) begin
          out_stall_i = 1'b1;
          run         = $urandom_range(0, 2);
        end else if (r < 93) begin
          out_stall_i = 1'b0;
          run         = $urandom_range(0, 4);
        end else begin
          out_stall_i = 1'b1;
          run         = $urandom_range(15, 50);
        end
      end
    end
  end

  // Result checker
  initial begin
    table_answer_t want;
    mismatches = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (table_answers.size() == 0) begin
          $display("%0t unexpected transaction: status %0d count %0d", $time,
                   status_o, entry_count_o);
          mismatches++;
        end else begin
          want = table_answers.pop_front();
          if (status_o !== want.status) begin
            $display("%0t status: expected %0d actual %0d", $time, want.status, status_o);
            mismatches++;
          end
          if (position_o !== want.position) begin
            $display("%0t position: expected %0d actual %0d", $time, want.position,
                     position_o);
            mismatches++;
          end
          if (read_key_o !== want.read_key) begin
            $display("%0t read_key: expected %h actual %h", $time, want.read_key,
                     read_key_o);
            mismatches++;
          end
          if (entry_count_o !== want.entry_count) begin
            $display("%0t entry_count: expected %0d actual %0d", $time,
                     want.entry_count, entry_count_o);
            mismatches++;
          end
        end
      end
    end
  end

  // Test sequence
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    in_valid_i   = 1'b0;
    operation_i  = OP_INSERT;
    key_i        = '0;
    index_i      = '0;
    hold_off_req = 1'b0;
    shadow_count = 0;
    shadow_dups  = 1'b0;
    foreach (shadow_keys[k]) shadow_keys[k] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_key_extremes();
    test_duplicates();
    test_random_narrow_pool();
    test_backpressure();
    test_random_wide_keys();
    test_full_table();

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
